FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the delay-based congestion window.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Implication with the consequent in the following cycle, outside of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/dbcw_pkg.sv
// ---------------------------------------------------------------------------
// dbcw_pkg
// Types and constants shared by the delay-based congestion window modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbcw_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned GAIN_W   = 3;
    localparam int unsigned RATIO_W  = 8;
    localparam int unsigned MEAN_W   = 40;
    localparam int unsigned DEV_W    = 35;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam int unsigned MAX_WINDOW_DEF = 65535;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(3);
    localparam logic [RATIO_W-1:0] UPPER_RST = RATIO_W'(48);
    localparam logic [RATIO_W-1:0] LOWER_RST = RATIO_W'(24);
    localparam logic [TIME_W-1:0]  TIMEOUT_RST = TIME_W'(1000);
    localparam logic [WIN_W-1:0]   WINDOW_RST  = WIN_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN_GAIN_SHIFT = 2'd0,
        CFG_UPPER_RATIO     = 2'd1,
        CFG_LOWER_RATIO     = 2'd2
    } t_cfg_idx;

    // Step controls for the state-update stage.
    typedef struct packed {
        logic load;     // item in the input stage updates the state
        logic advance;  // item in the update stage moves to the output stage
    } t_stage_ctl;

endpackage

`default_nettype wire

FILE: rtl/delay_based_congestion_window.sv
// ---------------------------------------------------------------------------
// delay_based_congestion_window
// Delay-based congestion window with a smoothed delay and timeout estimator.
// ---------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel is one acknowledgement with its send and
// arrival timestamps in milliseconds. Each one produces exactly one transfer on
// the output channel carrying the congestion window and the retransmit timeout
// in effect after that acknowledgement.
// The block has three register stages: the input register, the state-update
// stage and the output register. A result is valid once its input has passed
// the state-update stage into the output register. One acknowledgement can be
// taken every cycle while the receiver does not stall; the rate is set by the
// update stage, where the window, minimum delay, mean and deviation loops close.
// When the receiver stalls, the output register holds its result and the
// stages behind it fill up; input ready drops only when all three are full.
// Configuration writes are taken at any time on their own channel (ready is
// always high) and must only be issued while the block is empty.
// Reset clears the pipeline, restores the register defaults, sets the window
// to 5, the timeout to 1000 ms and marks the delay estimator as unseeded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module delay_based_congestion_window #(
    parameter int unsigned MAX_WINDOW = dbcw_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write channel.
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [dbcw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dbcw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Acknowledgement input channel.
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [dbcw_pkg::TIME_W-1:0]          i_sent_time_ms,
    input  wire logic [dbcw_pkg::TIME_W-1:0]          i_ack_time_ms,
    // Result output channel.
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic      [dbcw_pkg::WIN_W-1:0]           o_window_datagrams,
    output logic      [dbcw_pkg::TIME_W-1:0]          o_timeout_value_ms
);

    localparam int unsigned TW = dbcw_pkg::TIME_W;
    localparam int unsigned WW = dbcw_pkg::WIN_W;

    // Configuration registers.
    logic [dbcw_pkg::GAIN_W-1:0]  r_gain,  n_gain;
    logic [dbcw_pkg::RATIO_W-1:0] r_upper, n_upper;
    logic [dbcw_pkg::RATIO_W-1:0] r_lower, n_lower;

    // Pipeline occupancy and payload.
    logic          r_v1, n_v1;
    logic          r_v2, n_v2;
    logic          r_v3, n_v3;
    logic [TW-1:0] r_sent, n_sent;
    logic [TW-1:0] r_ack,  n_ack;
    logic [WW-1:0] r_out_window, n_out_window;

    logic          en1, en2, en3;
    logic [TW-1:0] delay;
    logic [WW-1:0] window;
    dbcw_pkg::t_stage_ctl ctl;

    // A stage may take new content when it is empty or its content moves on.
    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign ctl.load    = r_v1 && en2;
    assign ctl.advance = r_v2 && en3;

    // A negative difference is clamped to zero.
    assign delay = (r_ack >= r_sent) ? (r_ack - r_sent) : '0;

    always_comb begin
        n_gain  = r_gain;
        n_upper = r_upper;
        n_lower = r_lower;
        if (i_cfg_valid) begin
            case (dbcw_pkg::t_cfg_idx'(i_cfg_index))
                dbcw_pkg::CFG_MEAN_GAIN_SHIFT: n_gain  = i_cfg_data[dbcw_pkg::GAIN_W-1:0];
                dbcw_pkg::CFG_UPPER_RATIO:     n_upper = i_cfg_data;
                dbcw_pkg::CFG_LOWER_RATIO:     n_lower = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_v1 = en1 ? i_in_valid : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        n_v3 = en3 ? r_v2 : r_v3;

        n_sent = r_sent;
        n_ack  = r_ack;
        if (i_in_valid && en1) begin
            n_sent = i_sent_time_ms;
            n_ack  = i_ack_time_ms;
        end

        n_out_window = r_out_window;
        if (ctl.advance) begin
            n_out_window = window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= dbcw_pkg::GAIN_RST;
            r_upper <= dbcw_pkg::UPPER_RST;
            r_lower <= dbcw_pkg::LOWER_RST;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_gain  <= n_gain;
            r_upper <= n_upper;
            r_lower <= n_lower;
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_v3    <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sent       <= n_sent;
        r_ack        <= n_ack;
        r_out_window <= n_out_window;
    end

    dbcw_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_upper  (r_upper),
        .i_lower  (r_lower),
        .i_delay  (delay),
        .o_window (window)
    );

    // The timeout register only changes when an item enters the output stage,
    // so it serves directly as the output payload.
    dbcw_estimator u_estimator (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_gain    (r_gain),
        .i_delay   (delay),
        .o_timeout (o_timeout_value_ms)
    );

    assign o_cfg_ready        = 1'b1;
    assign o_in_ready         = en1;
    assign o_out_valid        = r_v3;
    assign o_window_datagrams = r_out_window;

endmodule

`default_nettype wire

FILE: rtl/dbcw_estimator.sv
// ---------------------------------------------------------------------------
// dbcw_estimator
// Smoothed delay mean and mean deviation, and the retransmit timeout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbcw_estimator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dbcw_pkg::t_stage_ctl              i_ctl,
    input  wire logic [dbcw_pkg::GAIN_W-1:0]       i_gain,
    input  wire logic [dbcw_pkg::TIME_W-1:0]       i_delay,
    output logic      [dbcw_pkg::TIME_W-1:0]       o_timeout
);

    localparam int unsigned MW = dbcw_pkg::MEAN_W;
    localparam int unsigned DW = dbcw_pkg::DEV_W;
    localparam int unsigned TW = dbcw_pkg::TIME_W;

    logic          r_have, n_have;
    logic          r_upd,  n_upd;
    logic [MW-1:0] r_mean, n_mean;
    logic [DW-1:0] r_dev,  n_dev;
    logic [TW-1:0] r_timeout, n_timeout;

    logic [MW-1:0] mean_sh;
    logic [MW-1:0] delay_ext;
    logic [MW:0]   mean_sum;
    logic [MW-1:0] abs_err;
    logic [DW-1:0] dev_decay;
    logic [MW:0]   dev_sum;
    logic [MW-1:0] cur_sh;
    logic [MW:0]   tmo_sum;

    always_comb begin
        delay_ext = MW'(i_delay);
        mean_sh   = r_mean >> i_gain;
        // r_mean - mean_sh never goes negative, so only the top needs a clamp.
        mean_sum  = {1'b0, r_mean} - {1'b0, mean_sh} + {1'b0, delay_ext};
        abs_err   = (delay_ext >= mean_sh) ? (delay_ext - mean_sh) : (mean_sh - delay_ext);
        dev_decay = r_dev - (r_dev >> 2);
        dev_sum   = (MW+1)'(dev_decay) + (MW+1)'(abs_err);

        n_have = r_have;
        n_upd  = r_upd;
        n_mean = r_mean;
        n_dev  = r_dev;
        if (i_ctl.load) begin
            n_have = 1'b1;
            n_upd  = r_have;
            if (!r_have) begin
                n_mean = delay_ext << i_gain;
                n_dev  = '0;
            end else begin
                n_mean = mean_sum[MW] ? {MW{1'b1}} : mean_sum[MW-1:0];
                n_dev  = (|dev_sum[MW:DW]) ? {DW{1'b1}} : dev_sum[DW-1:0];
            end
        end
    end

    // The timeout is formed from the state left by the item in the update stage.
    always_comb begin
        cur_sh    = r_mean >> i_gain;
        tmo_sum   = (MW+1)'(cur_sh) + (MW+1)'(r_dev);
        n_timeout = r_timeout;
        if (i_ctl.advance && r_upd) begin
            n_timeout = (|tmo_sum[MW:TW]) ? {TW{1'b1}} : tmo_sum[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have    <= 1'b0;
            r_upd     <= 1'b0;
            r_mean    <= '0;
            r_dev     <= '0;
            r_timeout <= dbcw_pkg::TIMEOUT_RST;
        end else begin
            r_have    <= n_have;
            r_upd     <= n_upd;
            r_mean    <= n_mean;
            r_dev     <= n_dev;
            r_timeout <= n_timeout;
        end
    end

    assign o_timeout = r_timeout;

endmodule

`default_nettype wire

FILE: rtl/dbcw_window.sv
// ---------------------------------------------------------------------------
// dbcw_window
// Minimum delay tracking and the delay-threshold congestion window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbcw_window #(
    parameter int unsigned MAX_WINDOW = dbcw_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dbcw_pkg::t_stage_ctl              i_ctl,
    input  wire logic [dbcw_pkg::RATIO_W-1:0]      i_upper,
    input  wire logic [dbcw_pkg::RATIO_W-1:0]      i_lower,
    input  wire logic [dbcw_pkg::TIME_W-1:0]       i_delay,
    output logic      [dbcw_pkg::WIN_W-1:0]        o_window
);

    localparam int unsigned TW = dbcw_pkg::TIME_W;
    localparam int unsigned WW = dbcw_pkg::WIN_W;
    localparam int unsigned PW = dbcw_pkg::TIME_W + dbcw_pkg::RATIO_W;
    localparam logic [WW-1:0] MaxWin = WW'(MAX_WINDOW);
    // floor(n / 100) = (n * RecipM) >> RecipK, exact for n below 2^17.
    localparam int unsigned RecipK = 24;
    localparam int unsigned NW     = WW + 1;
    localparam int unsigned RW     = 18;
    localparam logic [RW-1:0] RecipM = RW'(167773);

    logic [TW-1:0] r_min,    n_min;
    logic [WW-1:0] r_window, n_window;
    logic [WW-1:0] r_grow,   n_grow;

    logic [PW-1:0]    delay16;
    logic [PW-1:0]    hi_lim;
    logic [PW-1:0]    lo_lim;
    logic [NW-1:0]    ceil_num;
    logic [NW+RW-1:0] ceil_prod;
    logic [WW-1:0]    ceil_q;
    logic [WW-1:0]    shrunk;
    logic [WW-1:0]    grow_inc;

    always_comb begin
        n_min   = (i_delay < r_min) ? i_delay : r_min;
        delay16 = PW'({i_delay, 4'b0000});
        hi_lim  = PW'(i_upper) * PW'(n_min);
        lo_lim  = PW'(i_lower) * PW'(n_min);

        // floor(99w/100) = w - ceil(w/100)
        ceil_num  = NW'(r_window) + NW'(99);
        ceil_prod = (NW+RW)'(ceil_num) * (NW+RW)'(RecipM);
        ceil_q    = WW'(ceil_prod[NW+RW-1:RecipK]);
        shrunk    = r_window - ceil_q;

        grow_inc = (r_grow != {WW{1'b1}}) ? (r_grow + WW'(1)) : r_grow;

        n_window = r_window;
        n_grow   = r_grow;
        if (i_ctl.load) begin
            if (delay16 > hi_lim) begin
                n_grow   = '0;
                n_window = (shrunk == '0) ? WW'(1) : shrunk;
            end else if (delay16 <= lo_lim) begin
                if (grow_inc >= r_window) begin
                    n_grow   = '0;
                    n_window = (r_window < MaxWin) ? (r_window + WW'(1)) : r_window;
                end else begin
                    n_grow = grow_inc;
                end
            end
        end else begin
            n_min = r_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= {TW{1'b1}};
            r_window <= dbcw_pkg::WINDOW_RST;
            r_grow   <= '0;
        end else begin
            r_min    <= n_min;
            r_window <= n_window;
            r_grow   <= n_grow;
        end
    end

    assign o_window = r_window;

endmodule

`default_nettype wire

FILE: rtl/dbcw_checker.sv
// ---------------------------------------------------------------------------
// dbcw_checker
// Port-level checks on the delay-based congestion window, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dbcw_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_ready,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [dbcw_pkg::WIN_W-1:0]      o_window_datagrams,
    input  wire logic [dbcw_pkg::TIME_W-1:0]     o_timeout_value_ms
);

    // The window never collapses to zero.
    `ASSERT_CLK(a_window_nonzero, i_clk, i_rst_n, !o_out_valid || (o_window_datagrams != '0))

    // A stalled result keeps its values.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_window_datagrams) && $stable(o_timeout_value_ms))

    // With no result waiting, the pipeline always has room for an input.
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, o_out_valid || o_in_ready)

    // An accepted item reaches the output through the update and output stages if nothing stalls.
    `ASSERT_CLK(a_latency, i_clk, i_rst_n, ((i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready) |=> o_out_valid)

endmodule

bind delay_based_congestion_window dbcw_checker u_dbcw_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_window_datagrams (o_window_datagrams),
    .o_timeout_value_ms (o_timeout_value_ms)
);

`default_nettype wire
